[rtl/itrd_pkg.sv]
package itrd_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int NUM_W      = 31;
  localparam int RADIX_W    = 6;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int STEP_W     = $clog2(NUM_W);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FETCH,
    ST_SEND
  } state_t;

  function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    e = r;
    if (r < RADIX_MIN) begin
      e = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      e = RADIX_MAX;
    end
    return e;
  endfunction

  // Digits 0 to 9 map to '0'..'9', larger digits to 'A'..'Z'.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] c;
    logic [CHAR_W-1:0]  ch;
    c = (d > DIGIT_W'(35)) ? DIGIT_W'(35) : d;
    if (c < DIGIT_W'(10)) begin
      ch = CHAR_W'(48) + CHAR_W'(c);
    end else begin
      ch = CHAR_W'(55) + CHAR_W'(c);
    end
    return ch;
  endfunction

endpackage

[rtl/integer_to_radix_digits_top.sv]
// Converts a non-negative integer to ASCII digits in a programmable base.
// Input channel s_*: one request carries the number in s_tdata[30:0].
// Output channel m_*: one request per digit, most significant digit first,
// with the ASCII code in m_tdata[6:0] and tlast set on the final digit.
// Configuration channel cfg_*: cfg_data sets the base; values below 2 act
// as 2 and values above 36 act as 36. The base is sampled when a number is
// accepted, and cfg_ready is always high.
// Each digit comes from a bit-serial restoring divider with one quotient
// bit per cycle. A number with D digits (zero has one digit) runs D
// divisions, then reads each digit from the digit store in the fetch state
// and hands it to the output register in the send state.
// A new number is accepted only once the previous one has all its digits
// handed to the output register; the last digit may still wait there.
// When the receiver stalls, the block holds the current digit and waits.
// Reset sets the base to 10 and returns the block to idle; no clearing
// pass is needed.
module integer_to_radix_digits_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [30:0] number, [31] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [6:0] digit_char, [7] zero
  output logic                          m_tlast,   // last_digit
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [itrd_pkg::RADIX_W-1:0]  cfg_data   // radix
);
  import itrd_pkg::*;

  state_t               state, state_next;
  logic [RADIX_W-1:0]   radix;
  logic [RADIX_W-1:0]   base;
  logic [NUM_W-1:0]     quo;
  logic [DIGIT_W-1:0]   rem;
  logic [STEP_W-1:0]    step_cnt;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     idx;
  logic [DIGIT_W-1:0]   rd_data;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;
  logic                 out_valid;
  logic [DIGIT_W-1:0]   digit_store [MAX_DIGITS];

  logic [DIGIT_W:0]     trial;
  logic                 ge;
  logic [DIGIT_W:0]     rem_step;
  logic                 step_done;
  logic [NUM_W-1:0]     q_final;
  logic                 div_end;
  logic                 in_accept;
  logic                 out_free;
  logic                 load_out;

  assign trial     = {rem, quo[NUM_W-1]};
  assign ge        = trial >= {1'b0, base};
  assign rem_step  = ge ? (trial - {1'b0, base}) : trial;
  assign step_done = step_cnt == STEP_W'(NUM_W - 1);
  assign q_final   = {quo[NUM_W-2:0], ge};
  assign div_end   = (q_final == '0) || (count == CNT_W'(MAX_DIGITS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step_done && div_end) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) state_next = (idx == '0) ? ST_IDLE : ST_FETCH;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = state == ST_IDLE;
    out_free  = !out_valid || m_tready;
    load_out  = (state == ST_SEND) && out_free;
    in_accept = s_tvalid && s_tready;
  end

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {1'b0, out_char};
  assign m_tlast   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      radix     <= RADIX_RESET;
      out_valid <= 1'b0;
      count     <= '0;
      step_cnt  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        radix <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        count    <= '0;
        step_cnt <= '0;
      end else if (state == ST_DIVIDE) begin
        if (step_done) begin
          step_cnt <= '0;
          count    <= count + CNT_W'(1);
        end else begin
          step_cnt <= step_cnt + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      base <= effective_radix(radix);
      quo  <= s_tdata[NUM_W-1:0];
      rem  <= '0;
    end else if (state == ST_DIVIDE) begin
      quo <= q_final;
      rem <= step_done ? '0 : rem_step[DIGIT_W-1:0];
      if (step_done) begin
        digit_store[count[IDX_W-1:0]] <= rem_step[DIGIT_W-1:0];
        idx                           <= count[IDX_W-1:0];
      end
    end else if (load_out) begin
      idx <= idx - IDX_W'(1);
    end
    rd_data <= digit_store[idx];
    if (load_out) begin
      out_char <= digit_to_char(rd_data);
      out_last <= idx == '0;
    end
  end

  a_send_loads: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("digit not presented after load");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (base >= RADIX_MIN && base <= RADIX_MAX))
    else $error("base out of range during division");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (rem < base))
    else $error("partial remainder not below base");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_DIVIDE && step_cnt == '0 && count == '0))
    else $error("division did not start cleanly");

endmodule

[verif/radix_digit_checker.sv]
module radix_digit_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [31:0]                  s_tdata,   // [30:0] number, [31] zero
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [7:0]                   m_tdata,   // [6:0] digit_char, [7] zero
  input  logic                         m_tlast,   // last_digit
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [itrd_pkg::RADIX_W-1:0] cfg_data,  // radix
  output int                           mismatches,
  output int                           backlog
);
  import itrd_pkg::*;

  localparam logic [CHAR_W-1:0] CHAR_DIGIT0   = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER_A = 7'd65;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } digit_exp_t;

  digit_exp_t         expected_digits[$];
  logic [RADIX_W-1:0] radix_shadow;

  task automatic report_mismatch(input string what);
    $display("%0t: digit check failed: %s", $realtime, what);
    mismatches++;
  endtask

  // Divides repeatedly by the clamped base and queues the characters,
  // most significant digit first.
  task automatic expand_digits(input logic [NUM_W-1:0] value);
    logic [DIGIT_W-1:0] remainders [MAX_DIGITS];
    logic [NUM_W-1:0]   quotient;
    logic [DIGIT_W-1:0] d;
    int unsigned        base;
    int                 count;
    digit_exp_t         item;
    base = radix_shadow;
    if (radix_shadow < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_shadow > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    quotient = value;
    count    = 0;
    if (quotient == '0) begin
      remainders[0] = '0;
      count = 1;
    end else begin
      while (quotient != '0 && count < MAX_DIGITS) begin
        remainders[count] = DIGIT_W'(quotient % base);
        quotient = NUM_W'(quotient / base);
        count++;
      end
    end
    for (int k = count - 1; k >= 0; k--) begin
      d = remainders[k];
      item.char_code = (d < 10) ? CHAR_DIGIT0 + CHAR_W'(d) : CHAR_LETTER_A + CHAR_W'(d - 10);
      item.is_last   = (k == 0);
      expected_digits.insert(expected_digits.size(), item);
    end
  endtask

  always @(posedge clk) begin
    digit_exp_t head;
    if (rst) begin
      radix_shadow = RADIX_RESET;
      mismatches   = 0;
      expected_digits.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix_shadow = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        expand_digits(s_tdata[NUM_W-1:0]);
      end
      if (m_tvalid && m_tready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected digit 0x%02h last %b", m_tdata, m_tlast));
        end else begin
          head = expected_digits.pop_front();
          if (m_tdata !== {1'b0, head.char_code} || m_tlast !== head.is_last) begin
            report_mismatch($sformatf("got char 0x%02h last %b, expected 0x%02h last %b",
                                      m_tdata, m_tlast, head.char_code, head.is_last));
          end
        end
      end
    end
    backlog = expected_digits.size();
  end

endmodule

[verif/integer_to_radix_digits_top_tb.sv]
module integer_to_radix_digits_top_tb;
  import itrd_pkg::*;

  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [31:0]        s_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;
  logic               m_tlast;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data;
  int                 mismatches;
  int                 backlog;
  int                 tx_idle_pct;
  int                 rx_idle_pct;

  integer_to_radix_digits_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  radix_digit_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_number(input logic [NUM_W-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // The base may only change once every digit of the previous numbers is out.
  task automatic apply_radix(input logic [RADIX_W-1:0] radix);
    s_tvalid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= radix;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [RADIX_W-1:0] radix;
    logic [NUM_W-1:0]   value;
    longint unsigned    span;
    int unsigned        base_eff;
    int                 steps;
    int                 wait_cycles;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    tx_idle_pct = 18;
    rx_idle_pct = 68;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_number('0);
    send_number(NUM_MAX);
    send_number(NUM_W'(1));
    send_number(NUM_W'(9));
    send_number(NUM_W'(10));
    apply_radix(RADIX_W'(2));
    send_number(NUM_MAX);
    send_number('0);
    send_number(NUM_W'(1));
    apply_radix(RADIX_W'(36));
    send_number(NUM_W'(35));
    send_number(NUM_W'(36));
    send_number(NUM_MAX);
    apply_radix(RADIX_W'(0));
    send_number(NUM_W'(5));
    apply_radix(RADIX_W'(1));
    send_number(NUM_W'(6));
    apply_radix(RADIX_W'(37));
    send_number(NUM_W'(71));
    apply_radix(RADIX_W'(63));
    send_number(NUM_W'(1295));
    apply_radix(RADIX_W'(16));
    send_number(31'h2AAA_AAAA);
    send_number(31'h5555_5555);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 18;
          rx_idle_pct = 68;
        end
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 9; chunk++) begin
        case ($urandom_range(0, 7))
          0: radix = RADIX_MIN;
          1: radix = RADIX_MAX;
          2: radix = RADIX_W'($urandom_range(0, 63));
          default: radix = RADIX_W'($urandom_range(2, 36));
        endcase
        base_eff = (radix < RADIX_MIN) ? RADIX_MIN : (radix > RADIX_MAX) ? RADIX_MAX : radix;
        apply_radix(radix);
        for (int i = 0; i < 11; i++) begin
          case ($urandom_range(0, 9))
            0: value = '0;
            1: value = NUM_MAX;
            2, 3, 4: value = NUM_W'($urandom);
            5, 6: value = NUM_W'($urandom_range(0, 1000));
            default: begin
              // Values at a power of the base and just below it.
              span  = 1;
              steps = $urandom_range(1, 31);
              repeat (steps) begin
                if (span * base_eff <= NUM_MAX) begin
                  span = span * base_eff;
                end
              end
              value = NUM_W'(span - $urandom_range(0, 1));
            end
          endcase
          send_number(value);
        end
      end
    end

    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (backlog != 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (40) @(negedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("[integer_to_radix_digits_top] OK");
    end else begin
      $display("[integer_to_radix_digits_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[integer_to_radix_digits_top] ERROR");
    $finish;
  end

endmodule
